### rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants, codes and types of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;

    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [IDX_W-1:0] LAST_PAGE = IDX_W'(NUM_PAGES - 1);

    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic CFG_BASE     = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_REPLY = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CNT_W-1:0]    count;
        logic [IDX_W-1:0]    idx;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } t_result;

endpackage

### rtl/cpa_front.sv
// ----------------------------------------------------------------------------
// cpa_front
// Accepts request words, checks counts and free addresses, and queues
// the resulting commands for the engine.
// ----------------------------------------------------------------------------
module cpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [cpa_pkg::CNT_W-1:0]     i_count,
    input  logic [cpa_pkg::ADDR_W-1:0]    i_address,
    input  logic [cpa_pkg::ADDR_W-1:0]    i_base,
    input  logic                          i_hold,
    output logic                          o_cmd_valid,
    output cpa_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_ready
);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    cpa_pkg::t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]           r_wr;
    logic [Q_PTR_W-1:0]           r_rd;
    logic [Q_PTR_W:0]             r_cnt;

    cpa_pkg::t_cmd                w_cmd;
    logic [cpa_pkg::ADDR_W-1:0]   w_off;
    logic                         w_push;
    logic                         w_pop;

    assign w_off = i_address - i_base;

    always_comb begin
        w_cmd.op     = cpa_pkg::OP_REPLY;
        w_cmd.count  = i_count;
        w_cmd.idx    = w_off[cpa_pkg::PAGE_SHIFT +: cpa_pkg::IDX_W];
        w_cmd.status = cpa_pkg::ST_OK;
        unique case (i_kind)
            cpa_pkg::KIND_INIT: begin
                w_cmd.op = cpa_pkg::OP_INIT;
            end
            cpa_pkg::KIND_ALLOC: begin
                if (i_count == '0) begin
                    w_cmd.status = cpa_pkg::ST_BAD_COUNT;
                end else if (32'(i_count) > 32'(cpa_pkg::NUM_PAGES)) begin
                    w_cmd.status = cpa_pkg::ST_NO_ROOM;
                end else begin
                    w_cmd.op = cpa_pkg::OP_ALLOC;
                end
            end
            cpa_pkg::KIND_FREE: begin
                if (w_off[cpa_pkg::PAGE_SHIFT-1:0] != '0 ||
                    (w_off >> cpa_pkg::PAGE_SHIFT) >= 32'(cpa_pkg::NUM_PAGES)) begin
                    w_cmd.status = cpa_pkg::ST_NOT_FOUND;
                end else begin
                    w_cmd.op = cpa_pkg::OP_FREE;
                end
            end
            default: begin
                w_cmd.op = cpa_pkg::OP_REPLY;
            end
        endcase
    end

    assign o_in_ready  = (r_cnt != (Q_PTR_W+1)'(Q_DEPTH)) && !i_hold;
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/cpa_engine.sv
// ----------------------------------------------------------------------------
// cpa_engine
// Holds the page map and run lengths and carries out init, allocate and
// free commands by sweeping the map one page per cycle.
// ----------------------------------------------------------------------------
module cpa_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  cpa_pkg::t_cmd                 i_cmd,
    input  logic [cpa_pkg::ADDR_W-1:0]    i_base,
    input  logic [cpa_pkg::CNT_W-1:0]     i_reserved,
    output logic                          o_clearing,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output cpa_pkg::t_result              o_res
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_FILL   = 7'b0001000,
        S_LOOKUP = 7'b0010000,
        S_FREE   = 7'b0100000,
        S_REPLY  = 7'b1000000
    } t_state;

    localparam logic [cpa_pkg::CNT_W-1:0] CNT_ONE = cpa_pkg::CNT_W'(1);

    t_state                        r_state;
    logic [cpa_pkg::IDX_W-1:0]     r_ptr;
    logic [cpa_pkg::IDX_W-1:0]     r_end;
    logic [cpa_pkg::IDX_W-1:0]     r_rd_idx;
    logic                          r_rd_vld;
    logic                          r_issue_done;
    logic [cpa_pkg::CNT_W-1:0]     r_count;
    logic [cpa_pkg::CNT_W-1:0]     r_run;
    logic [cpa_pkg::CNT_W-1:0]     r_rem;
    logic [cpa_pkg::CNT_W-1:0]     r_limit;
    logic                          r_silent;
    cpa_pkg::t_result              r_res;
    logic                          r_o_valid;
    cpa_pkg::t_result              r_o;

    logic                          r_used_mem [cpa_pkg::NUM_PAGES];
    logic [cpa_pkg::CNT_W-1:0]     r_len_mem  [cpa_pkg::NUM_PAGES];
    logic                          r_used_q;
    logic [cpa_pkg::CNT_W-1:0]     r_len_q;

    logic                          w_we;
    logic                          w_used_wdata;
    logic [cpa_pkg::CNT_W-1:0]     w_len_wdata;
    logic [cpa_pkg::IDX_W-1:0]     w_len_raddr;
    logic [cpa_pkg::CNT_W-1:0]     w_run_n;
    logic [31:0]                   w_start_wide;
    logic [cpa_pkg::IDX_W-1:0]     w_start;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_clearing  = r_silent;
    assign o_res_valid = r_o_valid;
    assign o_res       = r_o;

    always_comb begin
        w_we         = 1'b0;
        w_used_wdata = 1'b0;
        w_len_wdata  = '0;
        unique case (r_state)
            S_INIT: begin
                w_we         = 1'b1;
                w_used_wdata = 32'(r_ptr) < 32'(r_limit);
            end
            S_FILL: begin
                w_we         = 1'b1;
                w_used_wdata = 1'b1;
                w_len_wdata  = r_count;
            end
            S_FREE: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_len_raddr  = (r_state == S_IDLE) ? i_cmd.idx : r_ptr;
    assign w_run_n      = r_used_q ? '0 : r_run + 1'b1;
    assign w_start_wide = 32'(r_rd_idx) + 32'd1 - 32'(r_count);
    assign w_start      = w_start_wide[cpa_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_used_mem[r_ptr] <= w_used_wdata;
            r_len_mem[r_ptr]  <= w_len_wdata;
        end
        r_used_q <= r_used_mem[r_ptr];
        r_len_q  <= r_len_mem[w_len_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_ptr        <= '0;
            r_limit      <= '0;
            r_silent     <= 1'b1;
            r_rd_vld     <= 1'b0;
            r_issue_done <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (r_o_valid && i_res_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_count      <= i_cmd.count;
                        r_res.status <= i_cmd.status;
                        r_res.addr   <= '0;
                        unique case (i_cmd.op)
                            cpa_pkg::OP_INIT: begin
                                r_ptr   <= '0;
                                r_limit <= i_reserved;
                                r_state <= S_INIT;
                            end
                            cpa_pkg::OP_ALLOC: begin
                                r_ptr        <= '0;
                                r_run        <= '0;
                                r_rd_vld     <= 1'b0;
                                r_issue_done <= 1'b0;
                                r_state      <= S_SCAN;
                            end
                            cpa_pkg::OP_FREE: begin
                                r_ptr   <= i_cmd.idx;
                                r_state <= S_LOOKUP;
                            end
                            default: begin
                                r_state <= S_REPLY;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == cpa_pkg::LAST_PAGE) begin
                        r_silent <= 1'b0;
                        r_state  <= r_silent ? S_IDLE : S_REPLY;
                    end
                end
                S_SCAN: begin
                    if (!r_issue_done) begin
                        r_ptr <= r_ptr + 1'b1;
                        if (r_ptr == cpa_pkg::LAST_PAGE) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    r_rd_vld <= !r_issue_done;
                    r_rd_idx <= r_ptr;
                    if (r_rd_vld) begin
                        r_run <= w_run_n;
                        if (w_run_n == r_count) begin
                            r_ptr      <= w_start;
                            r_end      <= r_rd_idx;
                            r_res.addr <= i_base + (32'(w_start) << cpa_pkg::PAGE_SHIFT);
                            r_state    <= S_FILL;
                        end else if (r_rd_idx == cpa_pkg::LAST_PAGE) begin
                            r_res.status <= cpa_pkg::ST_NO_ROOM;
                            r_state      <= S_REPLY;
                        end
                    end
                end
                S_FILL: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == r_end) begin
                        r_state <= S_REPLY;
                    end
                end
                S_LOOKUP: begin
                    r_rem   <= r_len_q;
                    r_state <= (r_len_q == '0) ? S_REPLY : S_FREE;
                end
                S_FREE: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_rem <= r_rem - 1'b1;
                    if (r_rem == CNT_ONE || r_ptr == cpa_pkg::LAST_PAGE) begin
                        r_state <= S_REPLY;
                    end
                end
                S_REPLY: begin
                    if (!r_o_valid || i_res_ready) begin
                        r_o_valid <= 1'b1;
                        r_o       <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/contiguous_page_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator_top
// First-fit contiguous page allocator with a request queue and a page-map
// sequencer.
// ----------------------------------------------------------------------------
// After reset the block clears its page map and takes no word until that pass
// is done. An init word clears the map again and marks the reserved pages used;
// an allocate word runs a first-fit scan and then marks the allocated pages;
// a free word looks up the run length and then frees that many pages, stopping
// at the last page; and a rejected word only returns its status. The page map
// and run-length memories are read or written at one page per cycle. A two-word
// queue in front of the sequencer accepts requests while one is being carried
// out.
module contiguous_page_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // page_count[10:0], address[42:11], zero fill
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_address[31:0]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    logic [cpa_pkg::ADDR_W-1:0]  r_base;
    logic [cpa_pkg::CNT_W-1:0]   r_reserved;

    logic                        w_cmd_valid;
    logic                        w_cmd_ready;
    cpa_pkg::t_cmd               w_cmd;
    logic                        w_clearing;
    cpa_pkg::t_result            w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_reserved <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cpa_pkg::CFG_BASE:     r_base     <= i_cfg_data;
                cpa_pkg::CFG_RESERVED: r_reserved <= i_cfg_data[cpa_pkg::CNT_W-1:0];
                default:               r_base     <= r_base;
            endcase
        end
    end

    cpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_count     (s_axis_tdata[10:0]),
        .i_address   (s_axis_tdata[42:11]),
        .i_base      (r_base),
        .i_hold      (w_clearing),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    cpa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_base      (r_base),
        .i_reserved  (r_reserved),
        .o_clearing  (w_clearing),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = w_res.addr;
    assign m_axis_tuser = w_res.status;

endmodule

### rtl/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks of the contiguous page allocator, bound to the top.
// ----------------------------------------------------------------------------
module cpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result word changed while stalled.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != cpa_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("Failed request returned a nonzero address.");

    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("Request accepted before the page map was cleared.");

endmodule

bind contiguous_page_allocator_top cpa_checker u_cpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the contiguous page allocator against a page-map predictor.
// Directed words cover the count limits, address matching on free, clamped
// frees and the reserved-page extremes. Random phases then mix allocations,
// frees of live runs, stray frees and re-inits under several pool bases and
// reserved counts. Both stream sides stall at random except in the last
// phase. Every reply is compared with the predicted status and address.
// ----------------------------------------------------------------------------
module tb_top;
    import cpa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 64;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_index   = CFG_BASE;
    logic [31:0]       i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata  = '0;  // page_count[10:0], address[42:11], zero fill
    logic [1:0]        s_axis_tuser  = '0;  // kind[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // result_address[31:0]
    logic [1:0]        m_axis_tuser;        // status[1:0]

    logic              page_used [NUM_PAGES];
    logic [CNT_W-1:0]  run_pages [NUM_PAGES];
    logic [ADDR_W-1:0] pool_base    = '0;
    logic [CNT_W-1:0]  reserved_cnt = '0;
    int                live_runs [$];
    t_result           pending_replies [$];
    bit                quiet       = 1'b0;
    int                errors      = 0;
    int                n_words     = 0;
    int                n_replies   = 0;
    int                idle_cycles = 0;
    int                stall_left  = 0;
    int                status_seen [4];

    contiguous_page_allocator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result predict_reply(logic [KIND_W-1:0] kind,
                                              logic [CNT_W-1:0] count,
                                              logic [ADDR_W-1:0] addr);
        t_result           res;
        int                run;
        int                start;
        int                idx;
        int                len;
        logic [ADDR_W-1:0] off;
        res.status = ST_OK;
        res.addr   = '0;
        case (kind)
            KIND_INIT: begin
                for (int i = 0; i < NUM_PAGES; i++) begin
                    page_used[i] = (i < reserved_cnt);
                    run_pages[i] = '0;
                end
                live_runs.delete();
            end
            KIND_ALLOC: begin
                if (count == 0) begin
                    res.status = ST_BAD_COUNT;
                end else if (count > NUM_PAGES) begin
                    res.status = ST_NO_ROOM;
                end else begin
                    run   = 0;
                    start = -1;
                    for (int i = 0; i < NUM_PAGES && start < 0; i++) begin
                        run = page_used[i] ? 0 : run + 1;
                        if (run == count) begin
                            start = i + 1 - count;
                        end
                    end
                    if (start < 0) begin
                        res.status = ST_NO_ROOM;
                    end else begin
                        for (int k = 0; k < count; k++) begin
                            page_used[start + k] = 1'b1;
                            run_pages[start + k] = count;
                        end
                        res.addr = pool_base + ADDR_W'(start) * ADDR_W'(PAGE_BYTES);
                        live_runs.push_back(start);
                    end
                end
            end
            KIND_FREE: begin
                off = addr - pool_base;
                if (off % PAGE_BYTES != 0 || off / PAGE_BYTES >= NUM_PAGES) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    idx = int'(off / PAGE_BYTES);
                    len = int'(run_pages[idx]);
                    for (int k = 0; k < len && idx + k < NUM_PAGES; k++) begin
                        page_used[idx + k] = 1'b0;
                        run_pages[idx + k] = '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_word(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] count,
                             logic [ADDR_W-1:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, addr, count};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(predict_reply(kind, count, addr));
        n_words++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic write_cfg(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] reserved);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_RESERVED;
        i_cfg_data  <= 32'(reserved);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pool_base    = base;
        reserved_cnt = reserved;
    endtask

    task automatic test_count_limits();
        write_cfg('0, '0);
        send_word(KIND_ALLOC, 11'd0, '0);
        send_word(KIND_ALLOC, 11'd1, '0);
        send_word(KIND_INIT, '0, '0);
        send_word(KIND_ALLOC, 11'd2047, '0);
        send_word(KIND_ALLOC, 11'(NUM_PAGES), '0);
        send_word(KIND_ALLOC, 11'd1, '0);
        // Freeing inside the full-pool run must stop at the last page.
        send_word(KIND_FREE, '0, ADDR_W'(1000) * ADDR_W'(PAGE_BYTES));
        send_word(KIND_UNUSED, 11'h7FF, 32'hFFFF_FFFF);
    endtask

    task automatic test_free_matching();
        write_cfg(32'hFFFF_F000, '0);
        send_word(KIND_INIT, '0, '0);
        send_word(KIND_ALLOC, 11'd3, '0);
        send_word(KIND_ALLOC, 11'd2, '0);
        send_word(KIND_FREE, '0, pool_base + ADDR_W'(PAGE_BYTES));
        send_word(KIND_FREE, '0, pool_base + ADDR_W'(4) * ADDR_W'(PAGE_BYTES));
        send_word(KIND_FREE, '0, 32'hFFFF_FFFF);
        send_word(KIND_FREE, '0, pool_base + ADDR_W'(NUM_PAGES) * ADDR_W'(PAGE_BYTES));
        send_word(KIND_FREE, '0, pool_base - ADDR_W'(PAGE_BYTES));
        send_word(KIND_FREE, '0, pool_base + ADDR_W'(10) * ADDR_W'(PAGE_BYTES));
    endtask

    task automatic test_reserved_extremes();
        write_cfg('0, 11'd2047);
        send_word(KIND_INIT, '0, '0);
        send_word(KIND_ALLOC, 11'd1, '0);
        write_cfg(32'h1234_5000, 11'(NUM_PAGES - 1));
        send_word(KIND_INIT, '0, '0);
        send_word(KIND_ALLOC, 11'd1, '0);
        send_word(KIND_ALLOC, 11'd1, '0);
        send_word(KIND_FREE, '0, pool_base + ADDR_W'(LAST_PAGE) * ADDR_W'(PAGE_BYTES));
        write_cfg('0, 11'(NUM_PAGES));
        send_word(KIND_INIT, '0, '0);
        send_word(KIND_ALLOC, 11'd1, '0);
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] reserved,
                             int n_items, bit pause_mid);
        int                sel;
        int                pick;
        int                pg;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] stray;
        write_cfg(base, reserved);
        send_word(KIND_INIT, 11'($urandom()), $urandom());
        for (int n = 0; n < n_items; n++) begin
            if (pause_mid && n == n_items / 2) begin
                drain();
            end
            sel = $urandom_range(0, 99);
            if (sel >= 38 && sel < 70 && live_runs.size() == 0) begin
                sel = 0;
            end
            if (sel < 38) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    cnt = 11'($urandom_range(1, 8));
                end else if (pick < 18) begin
                    cnt = 11'($urandom_range(9, 64));
                end else if (pick < 19) begin
                    cnt = 11'($urandom_range(65, 511));
                end else begin
                    cnt = 11'($urandom_range(512, NUM_PAGES));
                end
                send_word(KIND_ALLOC, cnt, $urandom());
            end else if (sel < 70) begin
                pick = $urandom_range(0, live_runs.size() - 1);
                pg   = live_runs[pick];
                live_runs.delete(pick);
                if ($urandom_range(0, 3) == 0 && run_pages[pg] > 1) begin
                    pg += $urandom_range(1, run_pages[pg] - 1);
                end
                send_word(KIND_FREE, 11'($urandom()),
                          pool_base + ADDR_W'(pg) * ADDR_W'(PAGE_BYTES));
            end else if (sel < 84) begin
                case ($urandom_range(0, 3))
                    0: stray = pool_base
                               + ADDR_W'($urandom_range(0, NUM_PAGES - 1)) * PAGE_BYTES;
                    1: stray = pool_base
                               + ADDR_W'($urandom_range(0, NUM_PAGES - 1)) * PAGE_BYTES
                               + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
                    2: stray = pool_base
                               + ADDR_W'($urandom_range(NUM_PAGES, 20'hFFFFF)) * PAGE_BYTES;
                    default: stray = $urandom();
                endcase
                send_word(KIND_FREE, 11'($urandom()), stray);
            end else if (sel < 90) begin
                send_word(KIND_INIT, 11'($urandom()), $urandom());
            end else if (sel < 94) begin
                send_word(KIND_UNUSED, 11'($urandom()), $urandom());
            end else if (sel < 97) begin
                send_word(KIND_ALLOC, 11'd0, $urandom());
            end else begin
                send_word(KIND_ALLOC, 11'($urandom_range(NUM_PAGES + 1, 2047)), $urandom());
            end
        end
    endtask

    task automatic test_random_traffic();
        run_phase($urandom() & 32'hFFFF_F000, 11'($urandom_range(0, 32)), 120, 1'b0);
        run_phase($urandom(), '0, 120, 1'b1);
        run_phase(32'hFFFF_F000, 11'($urandom_range(0, 200)), 120, 1'b0);
        run_phase('0, 11'd1000, 60, 1'b1);
        quiet = 1'b1;
        run_phase($urandom() & 32'hFFFF_F000, 11'($urandom_range(0, 64)), 120, 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_replies++;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual status %0d addr %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_replies.pop_front();
                status_seen[want.status]++;
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_axis_tuser);
                end
                if (m_axis_tdata !== want.addr) begin
                    errors++;
                    $display("%0t: address mismatch, expected %h, actual %h",
                             $time, want.addr, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("contiguous_page_allocator_top verification failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_PAGES; i++) begin
            page_used[i] = 1'b0;
            run_pages[i] = '0;
        end
        for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_count_limits();
        test_free_matching();
        test_reserved_extremes();
        test_random_traffic();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d request words and %0d replies over directed limits and five phases.",
                 n_words, n_replies);
        $display("Replies: ok %0d, no room %0d, bad count %0d, not found %0d; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_NO_ROOM], status_seen[ST_BAD_COUNT],
                 status_seen[ST_NOT_FOUND], errors);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("contiguous_page_allocator_top verification clean");
        end else begin
            $display("contiguous_page_allocator_top verification failed");
        end
        $finish;
    end

endmodule
